>>> hdl/xyzr_pkg.sv
// Shared constants and helpers for the xyz Euler vector rotator.
// No dependencies; imported by every module of the block.
package xyzr_pkg;

    // angle accumulator width (Q4.28 plus headroom for the residual)
    localparam int AW = 32;
    localparam int ATAN_ENTRIES = 30;

    typedef logic signed [AW-1:0] angle_t;

    localparam angle_t QUARTER_TURN = 32'sd421657428;
    localparam angle_t QUARTER_NEG  = -32'sd421657428;
    localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;

    // atan(2^-i) in Q4.28, rounded to nearest
    function automatic angle_t atan_q28(input logic [4:0] idx);
        angle_t r;
        case (idx)
            5'd0:  r = 32'sd210828714;
            5'd1:  r = 32'sd124459457;
            5'd2:  r = 32'sd65760959;
            5'd3:  r = 32'sd33381290;
            5'd4:  r = 32'sd16755422;
            5'd5:  r = 32'sd8385879;
            5'd6:  r = 32'sd4193963;
            5'd7:  r = 32'sd2097109;
            5'd8:  r = 32'sd1048571;
            5'd9:  r = 32'sd524287;
            5'd10: r = 32'sd262144;
            5'd11: r = 32'sd131072;
            5'd12: r = 32'sd65536;
            5'd13: r = 32'sd32768;
            5'd14: r = 32'sd16384;
            5'd15: r = 32'sd8192;
            5'd16: r = 32'sd4096;
            5'd17: r = 32'sd2048;
            5'd18: r = 32'sd1024;
            5'd19: r = 32'sd512;
            5'd20: r = 32'sd256;
            5'd21: r = 32'sd128;
            5'd22: r = 32'sd64;
            5'd23: r = 32'sd32;
            5'd24: r = 32'sd16;
            5'd25: r = 32'sd8;
            5'd26: r = 32'sd4;
            5'd27: r = 32'sd2;
            5'd28: r = 32'sd1;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/xyzr_cordic_stage.sv
// One registered rotation-mode CORDIC iteration with a side-data passenger.
// Depends on xyzr_pkg (arctangent table, angle type).
module xyzr_cordic_stage
    import xyzr_pkg::*;
#(
    parameter int DW     = 52,
    parameter int SIDE_W = 8,
    parameter int IDX    = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid_in,
    input  logic signed [DW-1:0] x_in,
    input  logic signed [DW-1:0] y_in,
    input  angle_t               a_in,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 valid_out,
    output logic signed [DW-1:0] x_out,
    output logic signed [DW-1:0] y_out,
    output angle_t               a_out,
    output logic [SIDE_W-1:0]    side_out
);

    localparam angle_t ATAN_I = atan_q28(5'(IDX));

    logic                 valid_reg;
    logic signed [DW-1:0] x_reg, x_next;
    logic signed [DW-1:0] y_reg, y_next;
    angle_t               a_reg, a_next;
    logic [SIDE_W-1:0]    side_reg;

    always_comb
    begin
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        dx = y_in >>> IDX;
        dy = x_in >>> IDX;
        if (a_in >= 0)
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            a_next = a_in - ATAN_I;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            a_next = a_in + ATAN_I;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        a_reg    <= a_next;
        side_reg <= side_in;
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign a_out     = a_reg;
    assign side_out  = side_reg;

endmodule

>>> hdl/xyzr_gain.sv
// Two-stage CORDIC gain compensation: |v| * K / 2^32, rounded half away from zero.
// Depends on xyzr_pkg (gain constant).
module xyzr_gain
    import xyzr_pkg::*;
#(
    parameter int DW = 52
)
(
    input  logic                 clk,
    input  logic signed [DW-1:0] v_in,
    output logic signed [DW-1:0] v_out
);

    logic [DW-1:0]        mag;
    logic [63:0]          prod_lo_reg, prod_lo_next;
    logic [DW-1:0]        prod_hi_reg, prod_hi_next;
    logic                 neg_reg;
    logic [64:0]          lo_rnd;
    logic [DW-1:0]        sum;
    logic signed [DW-1:0] res_reg, res_next;

    // magnitude split in two partial products, each at most 32x32
    assign mag          = v_in[DW-1] ? DW'(-v_in) : DW'(v_in);
    assign prod_lo_next = 64'(mag[31:0]) * 64'(GAIN_Q32);
    assign prod_hi_next = DW'(mag[DW-1:32]) * DW'(GAIN_Q32);

    always_ff @(posedge clk)
    begin
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
        neg_reg     <= v_in[DW-1];
    end

    assign lo_rnd   = 65'(prod_lo_reg) + 65'(32'h8000_0000);
    assign sum      = prod_hi_reg + DW'(lo_rnd >> 32);
    assign res_next = neg_reg ? -$signed(sum) : $signed(sum);

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign v_out = res_reg;

endmodule

>>> hdl/xyzr_plane_rotate.sv
// Pipelined plane rotation: quarter-turn stage, CORDIC chain, gain stages.
// Depends on xyzr_pkg, xyzr_cordic_stage and xyzr_gain.
module xyzr_plane_rotate
    import xyzr_pkg::*;
#(
    parameter int DW     = 52,
    parameter int SIDE_W = 8,
    parameter int NSTG   = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid_in,
    input  logic signed [DW-1:0] p_in,
    input  logic signed [DW-1:0] q_in,
    input  angle_t               a_in,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 valid_out,
    output logic signed [DW-1:0] p_out,
    output logic signed [DW-1:0] q_out,
    output logic [SIDE_W-1:0]    side_out
);

    logic                 valid_pipe [0:NSTG];
    logic signed [DW-1:0] x_pipe     [0:NSTG];
    logic signed [DW-1:0] y_pipe     [0:NSTG];
    angle_t               a_pipe     [0:NSTG];
    logic [SIDE_W-1:0]    side_pipe  [0:NSTG];

    logic                 valid_q_reg;
    logic signed [DW-1:0] xq_reg, xq_next;
    logic signed [DW-1:0] yq_reg, yq_next;
    angle_t               aq_reg, aq_next;
    logic [SIDE_W-1:0]    sideq_reg;

    logic [1:0]           valid_g_reg;
    logic [SIDE_W-1:0]    side_g1_reg, side_g2_reg;

    // exact quarter turns, at most two
    always_comb
    begin
        logic signed [DW-1:0] xt;
        logic signed [DW-1:0] yt;
        logic signed [DW-1:0] tt;
        angle_t               at;
        xt = p_in;
        yt = q_in;
        tt = '0;
        at = a_in;
        for (int t = 0; t < 2; t++)
        begin
            if (at > QUARTER_TURN)
            begin
                tt = xt;
                xt = -yt;
                yt = tt;
                at = at - QUARTER_TURN;
            end
            else if (at < QUARTER_NEG)
            begin
                tt = xt;
                xt = yt;
                yt = -tt;
                at = at + QUARTER_TURN;
            end
        end
        xq_next = xt;
        yq_next = yt;
        aq_next = at;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_q_reg <= 1'b0;
            valid_g_reg <= '0;
        end
        else
        begin
            valid_q_reg <= valid_in;
            valid_g_reg <= {valid_g_reg[0], valid_pipe[NSTG]};
        end
    end

    always_ff @(posedge clk)
    begin
        xq_reg      <= xq_next;
        yq_reg      <= yq_next;
        aq_reg      <= aq_next;
        sideq_reg   <= side_in;
        side_g1_reg <= side_pipe[NSTG];
        side_g2_reg <= side_g1_reg;
    end

    assign valid_pipe[0] = valid_q_reg;
    assign x_pipe[0]     = xq_reg;
    assign y_pipe[0]     = yq_reg;
    assign a_pipe[0]     = aq_reg;
    assign side_pipe[0]  = sideq_reg;

    for (genvar i = 0; i < NSTG; i++)
    begin : g_stage
        xyzr_cordic_stage #(
            .DW     (DW),
            .SIDE_W (SIDE_W),
            .IDX    (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_pipe[i]),
            .x_in      (x_pipe[i]),
            .y_in      (y_pipe[i]),
            .a_in      (a_pipe[i]),
            .side_in   (side_pipe[i]),
            .valid_out (valid_pipe[i+1]),
            .x_out     (x_pipe[i+1]),
            .y_out     (y_pipe[i+1]),
            .a_out     (a_pipe[i+1]),
            .side_out  (side_pipe[i+1])
        );
    end

    xyzr_gain #(.DW(DW)) u_gain_p (
        .clk   (clk),
        .v_in  (x_pipe[NSTG]),
        .v_out (p_out)
    );

    xyzr_gain #(.DW(DW)) u_gain_q (
        .clk   (clk),
        .v_in  (y_pipe[NSTG]),
        .v_out (q_out)
    );

    assign valid_out = valid_g_reg[1];
    assign side_out  = side_g2_reg;

endmodule

>>> hdl/xyz_euler_vector_rotate_core.sv
// Top level of the xyz Euler vector rotator: three chained plane rotations
// and the output rounding/saturation stage. Depends on xyzr_pkg and
// xyzr_plane_rotate.
//
// Rotates one Q16.16 vector about x, then y, then z by three Q3.28 angles.
// An item is taken whenever start is high; busy is always low, so one item
// may enter every clock. Each result appears on out_x/out_y/out_z/saturated
// for exactly one cycle with done high. Each rotation passes through a
// registered quarter-turn pre-rotation, a CORDIC chain of
// N = min(CORDIC_STAGES, 30) stages and the gain multiplier, and a final
// register rounds and saturates. Results leave in the order items arrived;
// the receiver cannot hold them off, so it must take every done cycle.
module xyz_euler_vector_rotate_core
    import xyzr_pkg::*;
#(
    parameter int CORDIC_STAGES = 24,
    parameter int FRAC_BITS     = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] vec_x,
    input  logic signed [31:0] vec_y,
    input  logic signed [31:0] vec_z,
    input  logic signed [30:0] angle_x,
    input  logic signed [30:0] angle_y,
    input  logic signed [30:0] angle_z,
    output logic               done,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic               saturated
);

    // chain length is capped by the arctangent table
    localparam int NSTG = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    // Q16.(16+FRAC_BITS) plus headroom for sqrt(3) growth and CORDIC gain
    localparam int DW   = 32 + FRAC_BITS + 4;
    localparam int S1_W = DW + 2*AW;
    localparam int S2_W = DW + AW;
    localparam int S3_W = DW;

    // input items are accepted every cycle
    assign busy = 1'b0;

    logic                 in_valid;
    logic signed [DW-1:0] x0, y0, z0;
    angle_t               ax, ay, az;

    assign in_valid = start & ~busy;
    assign x0 = {{(DW-32-FRAC_BITS){vec_x[31]}}, vec_x, {FRAC_BITS{1'b0}}};
    assign y0 = {{(DW-32-FRAC_BITS){vec_y[31]}}, vec_y, {FRAC_BITS{1'b0}}};
    assign z0 = {{(DW-32-FRAC_BITS){vec_z[31]}}, vec_z, {FRAC_BITS{1'b0}}};
    assign ax = {angle_x[30], angle_x};
    assign ay = {angle_y[30], angle_y};
    assign az = {angle_z[30], angle_z};

    // rotation about x: (y,z); x and the later angles ride along
    logic                 v1;
    logic signed [DW-1:0] y1, z1;
    logic [S1_W-1:0]      side1;

    xyzr_plane_rotate #(.DW(DW), .SIDE_W(S1_W), .NSTG(NSTG)) u_rot_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (in_valid),
        .p_in      (y0),
        .q_in      (z0),
        .a_in      (ax),
        .side_in   ({x0, ay, az}),
        .valid_out (v1),
        .p_out     (y1),
        .q_out     (z1),
        .side_out  (side1)
    );

    // rotation about y: (z,x)
    logic                 v2;
    logic signed [DW-1:0] z2, x2;
    logic [S2_W-1:0]      side2;
    logic signed [DW-1:0] x1;
    angle_t               ay1, az1;

    assign {x1, ay1, az1} = side1;

    xyzr_plane_rotate #(.DW(DW), .SIDE_W(S2_W), .NSTG(NSTG)) u_rot_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v1),
        .p_in      (z1),
        .q_in      (x1),
        .a_in      (ay1),
        .side_in   ({y1, az1}),
        .valid_out (v2),
        .p_out     (z2),
        .q_out     (x2),
        .side_out  (side2)
    );

    // rotation about z: (x,y)
    logic                 v3;
    logic signed [DW-1:0] x3, y3;
    logic [S3_W-1:0]      side3;
    logic signed [DW-1:0] y2;
    angle_t               az2;

    assign {y2, az2} = side2;

    xyzr_plane_rotate #(.DW(DW), .SIDE_W(S3_W), .NSTG(NSTG)) u_rot_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v2),
        .p_in      (x2),
        .q_in      (y2),
        .a_in      (az2),
        .side_in   (z2),
        .valid_out (v3),
        .p_out     (x3),
        .q_out     (y3),
        .side_out  (side3)
    );

    // round half up, drop FRAC_BITS, clip to 32 bits
    function automatic logic [32:0] round_clip(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] r;
        logic [32:0]          res;
        r = (v + (DW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r[DW-1:31] == {(DW-31){r[DW-1]}})
            res = {1'b0, r[31:0]};
        else if (r[DW-1])
            res = {1'b1, 32'h8000_0000};
        else
            res = {1'b1, 32'h7FFF_FFFF};
        return res;
    endfunction

    logic [32:0] rx, ry, rz;

    assign rx = round_clip(x3);
    assign ry = round_clip(y3);
    assign rz = round_clip(side3);

    logic               done_reg;
    logic signed [31:0] out_x_reg, out_y_reg, out_z_reg;
    logic               sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v3;
    end

    always_ff @(posedge clk)
    begin
        out_x_reg <= rx[31:0];
        out_y_reg <= ry[31:0];
        out_z_reg <= rz[31:0];
        sat_reg   <= rx[32] | ry[32] | rz[32];
    end

    assign done      = done_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    // flag only shown with its result
    assign saturated = done_reg & sat_reg;

endmodule

>>> hdl/xyzr_checker.sv
// Port-level checker for the xyz Euler vector rotator, bound to the top level.
// Depends on xyz_euler_vector_rotate_core (bind target) only.
module xyzr_checker #(
    parameter int CORDIC_STAGES = 24
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] out_x,
    input logic signed [31:0] out_y,
    input logic signed [31:0] out_z,
    input logic               saturated
);

    localparam int NSTG    = (CORDIC_STAGES < 30) ? CORDIC_STAGES : 30;
    localparam int LATENCY = 3 * (NSTG + 3) + 1;
    localparam int CW      = $clog2(LATENCY + 1);

    // cycles since reset, saturating at the pipeline depth
    logic [CW-1:0] warm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            warm_reg <= '0;
        else if (warm_reg != CW'(LATENCY))
            warm_reg <= warm_reg + 1'b1;
    end

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_sat_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        saturated |-> done)
        else $error("saturated without a result");

    a_sat_on_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |->
            (out_x == 32'sh7FFF_FFFF || out_x == 32'sh8000_0000 ||
             out_y == 32'sh7FFF_FFFF || out_y == 32'sh8000_0000 ||
             out_z == 32'sh7FFF_FFFF || out_z == 32'sh8000_0000))
        else $error("saturated flag with no clipped component");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (warm_reg == CW'(LATENCY)) |-> (done == $past(start && !busy, LATENCY)))
        else $error("result strobe does not match accepted item");

endmodule

bind xyz_euler_vector_rotate_core xyzr_checker #(
    .CORDIC_STAGES (CORDIC_STAGES)
) u_xyzr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .saturated (saturated)
);

>>> tb/tb_xyz_euler_vector_rotate_core.sv
// Self-checking testbench for xyz_euler_vector_rotate_core: drives vectors and
// Euler angles, predicts each rotated item in fixed point, checks every done.
// Depends only on the block's RTL (hdl/xyzr_pkg.sv, hdl/*.sv).
`timescale 1ns / 1ps

module tb_xyz_euler_vector_rotate_core;

    // block configuration, passed to the instance so both sides agree
    localparam int STAGES = 24;
    localparam int FRAC_B = 16;

    // fixed-point constants of the rotator
    localparam longint     QUARTER_Q28 = 64'sd421657428;   // pi/2, Q4.28
    localparam bit [63:0]  GAIN_K      = 64'h0000_0000_9B74_EDA8;
    localparam longint     ONE_Q       = 64'sd1 <<< FRAC_B;
    localparam longint     OUT_MAX     = 64'sd2147483647;
    localparam longint     OUT_MIN     = -64'sd2147483648;
    localparam longint     ATAN_Q28 [0:29] = '{
        210828714, 124459457, 65760959, 33381290, 16755422,
        8385879, 4193963, 2097109, 1048571, 524287,
        262144, 131072, 65536, 32768, 16384,
        8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16,
        8, 4, 2, 1, 0
    };

    // stimulus constants
    localparam int QT_INT     = 421657428;      // quarter turn
    localparam int HALF_TURN  = 843314856;      // pi
    localparam int ANG_LIMIT  = 843314857;      // nominal angle range
    localparam int FIELD_MAX  = 1073741823;     // 31-bit field top, about +4 rad
    localparam int FIELD_MIN  = -1073741824;
    localparam int UNIT       = 65536;          // 1.0 in Q16.16
    localparam int RANDOM_ITEMS = 1400;
    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT  = 2000;

    typedef struct {
        logic signed [31:0] vx, vy, vz;
        logic signed [30:0] ax, ay, az;
    } rot_in_t;

    typedef struct {
        logic signed [31:0] x, y, z;
        logic               sat;
    } rot_out_t;

    // Scoreboard: predicts the rotated vector of each accepted item and
    // checks results in arrival order (the block keeps items in order).
    class rotation_scoreboard;
        rot_out_t expected_q[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        // CORDIC gain compensation: |v|*K/2^32 rounded half away from zero
        function longint gain_comp(longint v);
            bit [63:0] mag, prod;
            mag  = (v < 0) ? 64'(-v) : 64'(v);
            prod = (mag >> 32) * GAIN_K
                 + (((mag & 64'hFFFF_FFFF) * GAIN_K + 64'h8000_0000) >> 32);
            return (v < 0) ? -longint'(prod) : longint'(prod);
        endfunction

        // plane rotation of (p,q) by ang: quarter-turn reduction, then CORDIC
        function void rotate_pair(input longint p_in, q_in, ang,
                                  output longint p_out, q_out);
            longint px, qy, res, t, dx, dy;
            px  = p_in;
            qy  = q_in;
            res = ang;
            for (int turn = 0; turn < 2; turn++)
            begin
                if (res > QUARTER_Q28)
                begin
                    t = px; px = -qy; qy = t;
                    res -= QUARTER_Q28;
                end
                else if (res < -QUARTER_Q28)
                begin
                    t = px; px = qy; qy = -t;
                    res += QUARTER_Q28;
                end
            end
            for (int i = 0; i < STAGES && i < 30; i++)
            begin
                dx = qy >>> i;
                dy = px >>> i;
                // zero residual counts as positive
                if (res >= 0)
                begin
                    px -= dx; qy += dy; res -= ATAN_Q28[i];
                end
                else
                begin
                    px += dx; qy -= dy; res += ATAN_Q28[i];
                end
            end
            p_out = gain_comp(px);
            q_out = gain_comp(qy);
        endfunction

        // round half up to Q16.16 and clip to 32 bits
        function logic [31:0] round_clip(input longint v, output bit clipped);
            longint r;
            r = (v + (64'sd1 <<< (FRAC_B - 1))) >>> FRAC_B;
            clipped = 1'b0;
            if (r > OUT_MAX)
            begin
                r = OUT_MAX;
                clipped = 1'b1;
            end
            else if (r < OUT_MIN)
            begin
                r = OUT_MIN;
                clipped = 1'b1;
            end
            return r[31:0];
        endfunction

        // accepted input item: work out its rotated vector
        function void log_input(rot_in_t it);
            longint   x, y, z;
            bit       cx, cy, cz;
            rot_out_t e;
            x = longint'(it.vx) * ONE_Q;
            y = longint'(it.vy) * ONE_Q;
            z = longint'(it.vz) * ONE_Q;
            rotate_pair(y, z, longint'(it.ax), y, z);   // about x
            rotate_pair(z, x, longint'(it.ay), z, x);   // about y
            rotate_pair(x, y, longint'(it.az), x, y);   // about z
            e.x   = round_clip(x, cx);
            e.y   = round_clip(y, cy);
            e.z   = round_clip(z, cz);
            e.sat = cx | cy | cz;
            expected_q.push_back(e);
        endfunction

        function void check_result(rot_out_t got);
            rot_out_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no item pending: x=%0d y=%0d z=%0d sat=%0b",
                             $realtime, got.x, got.y, got.z, got.sat);
                return;
            end
            e = expected_q.pop_front();
            if (got.x !== e.x || got.y !== e.y || got.z !== e.z || got.sat !== e.sat)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $write("%0t: mismatch: expected x=%0d y=%0d z=%0d sat=%0b,",
                           $realtime, e.x, e.y, e.z, e.sat);
                    $display(" got x=%0d y=%0d z=%0d sat=%0b",
                             got.x, got.y, got.z, got.sat);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] vec_x, vec_y, vec_z;
    logic signed [30:0] angle_x, angle_y, angle_z;
    logic               done;
    logic signed [31:0] out_x, out_y, out_z;
    logic               saturated;

    rotation_scoreboard sb;
    rot_in_t            seen_item;
    rot_out_t           seen_result;
    int                 burst_left;         // items left in a back-to-back stretch
    int                 stall_cycles = 0;   // cycles since anything was accepted or returned

    xyz_euler_vector_rotate_core #(
        .CORDIC_STAGES (STAGES),
        .FRAC_BITS     (FRAC_B)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .angle_x   (angle_x),
        .angle_y   (angle_y),
        .angle_z   (angle_z),
        .done      (done),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .saturated (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Input side: an item is taken at the edge where start is high and
    // busy is low. Values read here are the ones before this edge's updates.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            seen_item.vx = vec_x;
            seen_item.vy = vec_y;
            seen_item.vz = vec_z;
            seen_item.ax = angle_x;
            seen_item.ay = angle_y;
            seen_item.az = angle_z;
            sb.log_input(seen_item);
        end
    end

    // Result side: done lasts one cycle and cannot be held off, so every
    // done edge is a result.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen_result.x   = out_x;
            seen_result.y   = out_y;
            seen_result.z   = out_z;
            seen_result.sat = saturated;
            sb.check_result(seen_result);
        end
    end

    // watchdog counter: cleared by any accepted item or result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("FAIL xyz_euler_vector_rotate_core");
        $finish;
    end

    // Present one item after a random idle gap, hold it until taken.
    // Gaps may be empty, with occasional back-to-back stretches.
    task automatic send(input logic signed [31:0] vx, vy, vz,
                        input logic signed [30:0] ax, ay, az);
        int gap;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 13);
            if ($urandom_range(0, 15) == 0)
                burst_left = $urandom_range(8, 40);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        vec_x   <= vx;
        vec_y   <= vy;
        vec_z   <= vz;
        angle_x <= ax;
        angle_y <= ay;
        angle_z <= az;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Angle mix: mostly the nominal +-pi range, some right at the quarter
    // and half turn boundaries, some over the whole 31-bit field (+-4 rad).
    function automatic logic signed [30:0] rand_angle();
        int                 sel;
        logic signed [30:0] a;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            a = 31'(int'($urandom_range(0, 2 * ANG_LIMIT)) - ANG_LIMIT);
        else if (sel < 8)
        begin
            a = 31'(QT_INT * int'($urandom_range(1, 2)) + int'($urandom_range(0, 8)) - 4);
            if ($urandom_range(0, 1) == 1)
                a = -a;
        end
        else
            a = 31'($urandom);
        return a;
    endfunction

    // Component mix: full range (saturates often), small values, and values
    // pressed against either end of the range.
    function automatic logic signed [31:0] rand_component();
        int                 sel;
        logic signed [31:0] c;
        sel = $urandom_range(0, 7);
        if (sel < 4)
            c = $urandom;
        else if (sel < 6)
            c = int'($urandom_range(0, 2097151)) - 1048576;
        else if ($urandom_range(0, 1) == 1)
            c = 32'sh7FFF_FFFF - int'($urandom_range(0, 255));
        else
            c = 32'sh8000_0000 + int'($urandom_range(0, 255));
        return c;
    endfunction

    initial
    begin
        sb = new();
        burst_left = 0;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        vec_x   <= '0;
        vec_y   <= '0;
        vec_z   <= '0;
        angle_x <= '0;
        angle_y <= '0;
        angle_z <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero, unit vectors, quarter-turn edges
        send(0, 0, 0, 0, 0, 0);
        send(UNIT, 0, 0, 0, 0, 0);
        send(0, UNIT, 0, QT_INT, 0, 0);            // exactly a quarter turn
        send(0, UNIT, 0, QT_INT + 1, 0, 0);        // just beyond: one exact turn
        send(0, 0, UNIT, -QT_INT, 0, 0);
        send(0, 0, UNIT, -QT_INT - 1, 0, 0);
        // two exact turns, then the extremes of the nominal range
        send(UNIT, 2 * UNIT, 3 * UNIT, 0, ANG_LIMIT, 0);
        send(UNIT, 2 * UNIT, 3 * UNIT, 0, 0, -ANG_LIMIT);
        // beyond +-pi, up to the limits of the 31-bit field
        send(UNIT, 2 * UNIT, 3 * UNIT, FIELD_MAX, FIELD_MIN, FIELD_MAX);
        send(-UNIT, UNIT, -UNIT, FIELD_MIN, FIELD_MAX, FIELD_MIN);
        // full-scale vectors, with and without overflow
        send(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0);
        send(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0);
        send(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, QT_INT / 2);
        send(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, HALF_TURN, 0, 0);
        send(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, QT_INT, QT_INT, QT_INT);
        send(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
             -HALF_TURN, -HALF_TURN, -HALF_TURN);
        // alternating bit patterns on every field
        send(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
             31'sh2AAA_AAAA, 31'sh5555_5555, 31'sh2AAA_AAAA);
        send(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
             31'sh5555_5555, 31'sh2AAA_AAAA, 31'sh5555_5555);
        // tiny residuals either side of zero, smallest vector values
        send(UNIT, UNIT, UNIT, -1, -1, -1);
        send(UNIT, UNIT, UNIT, 1, 1, 1);
        send(-1, -1, -1, 1, -1, 1);
        send(1, 1, 1, -QT_INT - 1, QT_INT + 1, HALF_TURN);

        for (int n = 0; n < RANDOM_ITEMS; n++)
            send(rand_component(), rand_component(), rand_component(),
                 rand_angle(), rand_angle(), rand_angle());
        start <= 1'b0;

        // drain the pipeline, then watch for stray results
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS xyz_euler_vector_rotate_core");
        else
            $display("FAIL xyz_euler_vector_rotate_core");
        $finish;
    end

endmodule
